FILE: sv/jetp_pkg.sv
// Shared types and constants for the Julia escape-time pixel core.
`timescale 1ns / 1ps
package jetp_pkg;

   localparam int WORD_W     = 64;
   localparam int PIX_W      = 12;
   localparam int DIM_W      = 13;
   localparam int CNT_W      = 10;
   localparam int CREG_W     = 32;
   localparam int LEVEL_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int FIFO_DEPTH = 2;

   localparam logic [DIM_W-1:0] RST_WIDTH    = 13'd512;
   localparam logic [DIM_W-1:0] RST_HEIGHT   = 13'd512;
   localparam logic [CNT_W-1:0] RST_MIN_ITER = 10'd0;
   localparam logic [CNT_W-1:0] RST_MAX_ITER = 10'd255;
   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_C_REAL,
      CSR_C_IMAG,
      CSR_WIDTH,
      CSR_HEIGHT,
      CSR_MIN_ITER,
      CSR_MAX_ITER
   } csr_index_type;

   typedef struct packed {
      logic signed [CREG_W-1:0] c_real;
      logic signed [CREG_W-1:0] c_imag;
      logic [DIM_W-1:0]         image_width;
      logic [DIM_W-1:0]         image_height;
      logic [CNT_W-1:0]         min_iterations;
      logic [CNT_W-1:0]         max_iterations;
   } cfg_type;

   typedef struct packed {
      logic [WORD_W-1:0] re;
      logic [WORD_W-1:0] im;
   } zpair_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_RUN,
      FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_CHECK,
      BK_DIV,
      BK_OUT
   } back_state_type;

   // which of the three products a partial product belongs to
   typedef enum logic [1:0] {
      PROD_RR,
      PROD_II,
      PROD_RI
   } prod_sel_type;

endpackage

FILE: sv/jetp_if.sv
// Handshake channel interfaces for pixel requests, results and register writes.
`timescale 1ns / 1ps
interface jetp_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] pixel_x;
   logic [11:0] pixel_y;
   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface jetp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] escape_level;
   logic [7:0] red_channel;
   logic [7:0] green_blue_channel;
   modport source (output valid, output escape_level, output red_channel,
                   output green_blue_channel, input ready);
   modport sink (input valid, input escape_level, input red_channel,
                 input green_blue_channel, output ready);
endinterface

interface jetp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/jetp_front.sv
// Front end: accepts a pixel and scales it to the start point z0 with bit-serial dividers.
`timescale 1ns / 1ps
module jetp_front import jetp_pkg::*; #(
   parameter int FRAC_BITS  = 28,
   parameter int PIXEL_BITS = 12
) (
   input  logic      clock,
   input  logic      reset,
   jetp_req_if.sink  req_bus,
   input  cfg_type   cfg,
   output logic      push_valid,
   input  logic      push_ready,
   output zpair_type push_data
);

   localparam int PW     = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
   localparam int STEPS  = PW + FRAC_BITS + 2;
   localparam int STEP_W = $clog2(STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);
   localparam logic [WORD_W-1:0] TWO = {{(WORD_W-2){1'b0}}, 2'b10} << FRAC_BITS;

   front_state_type state_ff, state_in;

   logic [STEP_W-1:0] step_ff;
   logic [PW-1:0]     numx_ff, numy_ff;
   logic [DIM_W-1:0]  remx_ff, remy_ff, remx_in, remy_in;
   logic [WORD_W-1:0] quox_ff, quoy_ff;
   logic [DIM_W-1:0]  dx, dy;
   logic [DIM_W:0]    tx, ty;
   logic              gex, gey;
   logic              accept;

   // a zero dimension scales as one
   assign dx = (cfg.image_width == '0) ? DIM_W'(1) : cfg.image_width;
   assign dy = (cfg.image_height == '0) ? DIM_W'(1) : cfg.image_height;

   // numerator is pixel << (FRAC_BITS+2); zeros shift in behind the pixel bits
   assign tx  = {remx_ff, numx_ff[PW-1]};
   assign ty  = {remy_ff, numy_ff[PW-1]};
   assign gex = tx >= {1'b0, dx};
   assign gey = ty >= {1'b0, dy};
   assign remx_in = gex ? DIM_W'(tx - {1'b0, dx}) : tx[DIM_W-1:0];
   assign remy_in = gey ? DIM_W'(ty - {1'b0, dy}) : ty[DIM_W-1:0];

   assign push_data.re = quox_ff - TWO;
   assign push_data.im = quoy_ff - TWO;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_bus.ready  = 1'b0;
      push_valid     = 1'b0;
      accept         = 1'b0;
      unique case (state_ff)
         FR_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               accept   = 1'b1;
               state_in = FR_RUN;
            end
         end
         FR_RUN: begin
            if (step_ff == LAST_STEP) begin
               state_in = FR_PUSH;
            end
         end
         FR_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         step_ff <= '0;
         numx_ff <= req_bus.pixel_x[PW-1:0];
         numy_ff <= req_bus.pixel_y[PW-1:0];
         remx_ff <= '0;
         remy_ff <= '0;
         quox_ff <= '0;
         quoy_ff <= '0;
      end else if (state_ff == FR_RUN) begin
         step_ff <= STEP_W'(step_ff + 1'b1);
         numx_ff <= {numx_ff[PW-2:0], 1'b0};
         numy_ff <= {numy_ff[PW-2:0], 1'b0};
         remx_ff <= remx_in;
         remy_ff <= remy_in;
         quox_ff <= {quox_ff[WORD_W-2:0], gex};
         quoy_ff <= {quoy_ff[WORD_W-2:0], gey};
      end
   end

endmodule

FILE: sv/jetp_fifo.sv
// Short queue of start points between the front and back ends.
`timescale 1ns / 1ps
module jetp_fifo import jetp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  zpair_type push_data,
   output logic      pop_valid,
   input  logic      pop_ready,
   output zpair_type pop_data
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   zpair_type        mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   fill_ff;
   logic             do_push, do_pop;

   assign push_ready = fill_ff != (PTR_W + 1)'(FIFO_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (do_pop) begin
            rd_ptr_ff <= PTR_W'(rd_ptr_ff + 1'b1);
         end
         case ({do_push, do_pop})
            2'b10:   fill_ff <= (PTR_W + 1)'(fill_ff + 1'b1);
            2'b01:   fill_ff <= (PTR_W + 1)'(fill_ff - 1'b1);
            default: fill_ff <= fill_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/jetp_back.sv
// Back end: iterates z = z*z + c on one shared multiplier and scales the escape count.
`timescale 1ns / 1ps
module jetp_back import jetp_pkg::*; #(
   parameter int FRAC_BITS = 28
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  zpair_type  pop_data,
   jetp_rsp_if.source rsp_bus
);

   localparam int ACC_W  = FRAC_BITS + WORD_W;
   localparam int HALF_W = WORD_W / 2;
   localparam int MUL_W  = HALF_W + 1;
   localparam int PROD_W = 2 * MUL_W;
   localparam int CNT_X  = CNT_W + 1;
   localparam int DIVD_W = CNT_W + LEVEL_W;
   localparam int SHL    = (FRAC_BITS >= 28) ? FRAC_BITS - 28 : 0;
   localparam int SHR    = (FRAC_BITS < 28) ? 28 - FRAC_BITS : 0;
   localparam logic [3:0] MUL_STEPS = 4'd12;
   localparam logic [2:0] DIV_LAST  = 3'd7;
   localparam logic [WORD_W-1:0] FOUR = {{(WORD_W-3){1'b0}}, 3'b100} << FRAC_BITS;

   back_state_type state_ff, state_in;

   logic [3:0]         step_ff;
   logic [WORD_W-1:0]  zr_ff, zi_ff, rr_ff, ii_ff, ri_ff;
   logic [CNT_X-1:0]   count_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic               tag_valid_ff, tag_last_ff;
   prod_sel_type       tag_dest_ff;
   logic [1:0]         tag_shift_ff;
   logic [CNT_W-1:0]   rem_ff;
   logic [LEVEL_W-1:0] dlow_ff, quo_ff;
   logic [2:0]         div_step_ff;
   logic               rsp_valid_ff;
   logic [LEVEL_W-1:0] level_out_ff, red_out_ff, gb_out_ff;

   logic               take, issue, load_out;
   logic signed [WORD_W-1:0] cr_ext, ci_ext;
   logic [WORD_W-1:0]  cr, ci;
   prod_sel_type       sel;
   logic [1:0]         part;
   logic [WORD_W-1:0]  opa, opb;
   logic signed [MUL_W-1:0] ma, mb;
   logic [ACC_W-1:0]   pext, pshift, acc_sum;
   logic [WORD_W-1:0]  mag_sum;
   logic               stop;
   logic [DIVD_W-1:0]  dividend;
   logic [CNT_W:0]     dtrial;
   logic               dge;
   logic [CNT_W-1:0]   rem_in;
   logic [LEVEL_W-1:0] quo_in;

   // Q4.28 register to working format
   assign cr_ext = {{(WORD_W-CREG_W){cfg.c_real[CREG_W-1]}}, cfg.c_real};
   assign ci_ext = {{(WORD_W-CREG_W){cfg.c_imag[CREG_W-1]}}, cfg.c_imag};
   assign cr = (FRAC_BITS >= 28) ? WORD_W'(cr_ext << SHL) : WORD_W'(cr_ext >>> SHR);
   assign ci = (FRAC_BITS >= 28) ? WORD_W'(ci_ext << SHL) : WORD_W'(ci_ext >>> SHR);

   // partial product schedule: step[3:2] picks the product, step[1:0] the halves
   assign sel  = prod_sel_type'(step_ff[3:2]);
   assign part = step_ff[1:0];
   assign opa  = (sel == PROD_II) ? zi_ff : zr_ff;
   assign opb  = (sel == PROD_RR) ? zr_ff : zi_ff;
   assign ma   = part[0] ? $signed({opa[WORD_W-1], opa[WORD_W-1:HALF_W]})
                         : $signed({1'b0, opa[HALF_W-1:0]});
   assign mb   = part[1] ? $signed({opb[WORD_W-1], opb[WORD_W-1:HALF_W]})
                         : $signed({1'b0, opb[HALF_W-1:0]});
   assign issue = (state_ff == BK_MUL) && (step_ff < MUL_STEPS);

   assign pext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   always_comb begin
      case (tag_shift_ff)
         2'd0:    pshift = pext;
         2'd1:    pshift = pext << HALF_W;
         default: pshift = pext << WORD_W;
      endcase
   end
   assign acc_sum = acc_ff + pshift;

   assign mag_sum = rr_ff + ii_ff;
   assign stop = !($signed(mag_sum) < $signed(FOUR))
              || (count_ff > {1'b0, cfg.max_iterations});

   // 255*count as (count << 8) - count
   assign dividend = {count_ff[CNT_W-1:0], {LEVEL_W{1'b0}}}
                   - {{LEVEL_W{1'b0}}, count_ff[CNT_W-1:0]};
   assign dtrial = {rem_ff, dlow_ff[LEVEL_W-1]};
   assign dge    = dtrial >= {1'b0, cfg.max_iterations};
   assign rem_in = dge ? CNT_W'(dtrial - {1'b0, cfg.max_iterations}) : dtrial[CNT_W-1:0];
   assign quo_in = {quo_ff[LEVEL_W-2:0], dge};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pop_ready = 1'b0;
      take      = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               take     = 1'b1;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            if (step_ff == MUL_STEPS) begin
               state_in = BK_CHECK;
            end
         end
         BK_CHECK: begin
            if (!stop) begin
               state_in = BK_MUL;
            end else if (count_ff < {1'b0, cfg.max_iterations}) begin
               state_in = BK_DIV;
            end else begin
               state_in = BK_OUT;
            end
         end
         BK_DIV: begin
            if (div_step_ff == DIV_LAST) begin
               state_in = BK_OUT;
            end
         end
         BK_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               load_out = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_valid_ff <= 1'b0;
      end else begin
         tag_valid_ff <= issue;
      end
   end

   // multiplier stage, registered with its routing tag
   always_ff @(posedge clock) begin
      if (issue) begin
         prod_ff      <= ma * mb;
         tag_dest_ff  <= sel;
         tag_last_ff  <= part == 2'd3;
         tag_shift_ff <= {1'b0, part[0]} + {1'b0, part[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         zr_ff    <= pop_data.re;
         zi_ff    <= pop_data.im;
         count_ff <= {1'b0, cfg.min_iterations};
         acc_ff   <= '0;
         step_ff  <= '0;
      end else begin
         if (state_ff == BK_MUL) begin
            step_ff <= 4'(step_ff + 1'b1);
         end
         if (tag_valid_ff) begin
            if (tag_last_ff) begin
               acc_ff <= '0;
               case (tag_dest_ff)
                  PROD_RR: rr_ff <= acc_sum[FRAC_BITS +: WORD_W];
                  PROD_II: ii_ff <= acc_sum[FRAC_BITS +: WORD_W];
                  default: ri_ff <= acc_sum[FRAC_BITS +: WORD_W];
               endcase
            end else begin
               acc_ff <= acc_sum;
            end
         end
         if (state_ff == BK_CHECK) begin
            if (!stop) begin
               zr_ff    <= rr_ff - ii_ff + cr;
               zi_ff    <= {ri_ff[WORD_W-2:0], 1'b0} + ci;
               count_ff <= CNT_X'(count_ff + 1'b1);
               step_ff  <= '0;
            end else begin
               rem_ff      <= dividend[DIVD_W-1:LEVEL_W];
               dlow_ff     <= dividend[LEVEL_W-1:0];
               quo_ff      <= '0;
               div_step_ff <= '0;
            end
         end
         if (state_ff == BK_DIV) begin
            rem_ff      <= rem_in;
            dlow_ff     <= {dlow_ff[LEVEL_W-2:0], 1'b0};
            quo_ff      <= quo_in;
            div_step_ff <= 3'(div_step_ff + 1'b1);
         end
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         level_out_ff <= quo_ff;
         red_out_ff   <= (quo_ff != '0) ? LEVEL_FULL : '0;
         gb_out_ff    <= (quo_ff != '0) ? LEVEL_W'(LEVEL_FULL - quo_ff) : '0;
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.escape_level       = level_out_ff;
   assign rsp_bus.red_channel        = red_out_ff;
   assign rsp_bus.green_blue_channel = gb_out_ff;

endmodule

FILE: sv/julia_escape_time_pixel_core.sv
// Top level of the Julia escape-time pixel core: register file, front end, queue, back end.
`timescale 1ns / 1ps
// Each request word carries one pixel position; the core maps it to a start
// point in the square [-2, 2) x [-2, 2) scaled by image_width/image_height,
// iterates z = z*z + c and returns one word with the escape level and its
// color. The front end finds the start point with one-bit-per-cycle
// coordinate dividers, and a two-entry queue lets it run ahead of the
// back end. The back end makes at most max(1, max_iterations -
// min_iterations + 2) passes per pixel: every pass runs twelve 33x33-bit
// partial products through the single shared multiplier, and a nonzero
// escape level comes from a serial divider. Registers may only be written
// while no pixel is in flight.
module julia_escape_time_pixel_core import jetp_pkg::*; #(
   parameter int FRAC_BITS  = 28,
   parameter int PIXEL_BITS = 12
) (
   input  logic       clock,
   input  logic       reset,
   jetp_req_if.sink   req_bus,
   jetp_rsp_if.source rsp_bus,
   jetp_csr_if.sink   csr_bus
);

   cfg_type   cfg_ff;
   logic      front_valid, front_ready;
   zpair_type front_data;
   logic      queue_valid, queue_ready;
   zpair_type queue_data;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.c_real         <= '0;
         cfg_ff.c_imag         <= '0;
         cfg_ff.image_width    <= RST_WIDTH;
         cfg_ff.image_height   <= RST_HEIGHT;
         cfg_ff.min_iterations <= RST_MIN_ITER;
         cfg_ff.max_iterations <= RST_MAX_ITER;
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_C_REAL:   cfg_ff.c_real         <= csr_bus.data[CREG_W-1:0];
            CSR_C_IMAG:   cfg_ff.c_imag         <= csr_bus.data[CREG_W-1:0];
            CSR_WIDTH:    cfg_ff.image_width    <= csr_bus.data[DIM_W-1:0];
            CSR_HEIGHT:   cfg_ff.image_height   <= csr_bus.data[DIM_W-1:0];
            CSR_MIN_ITER: cfg_ff.min_iterations <= csr_bus.data[CNT_W-1:0];
            CSR_MAX_ITER: cfg_ff.max_iterations <= csr_bus.data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   jetp_front #(
      .FRAC_BITS  (FRAC_BITS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg_ff),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_data)
   );

   jetp_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_data),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_data)
   );

   jetp_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (queue_valid),
      .pop_ready (queue_ready),
      .pop_data  (queue_data),
      .rsp_bus   (rsp_bus)
   );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the Julia escape-time pixel core.
`timescale 1ns / 1ps
module tb;
   import jetp_pkg::*;

   localparam int HOLD_CYCLES      = 3000;
   localparam int STUCK_LIMIT      = 100000;
   localparam int SETTLE_CYCLES    = 20;
   localparam int RANDOM_PHASES    = 12;
   localparam int ITEMS_PER_PHASE  = 40;

   // Predicts the color word for each accepted pixel and checks the results in order.
   class pixel_scoreboard;
      localparam int FRAC = 28;
      localparam logic signed [63:0] FOUR_Q = 64'sd4 << FRAC;

      typedef struct packed {
         logic [7:0] level;
         logic [7:0] red;
         logic [7:0] green_blue;
      } pixel_color_type;

      logic [31:0] c_real         = '0;
      logic [31:0] c_imag         = '0;
      logic [12:0] image_width    = RST_WIDTH;
      logic [12:0] image_height   = RST_HEIGHT;
      logic [9:0]  min_iterations = RST_MIN_ITER;
      logic [9:0]  max_iterations = RST_MAX_ITER;
      pixel_color_type colors_due[$];
      int errors       = 0;
      int results_seen = 0;

      task report(string msg);
         $display("%0t mismatch: %s", $time, msg);
         errors++;
      endtask

      function int pending();
         return colors_due.size();
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] data);
         case (idx)
            CSR_C_REAL:   c_real = data;
            CSR_C_IMAG:   c_imag = data;
            CSR_WIDTH:    image_width = data[12:0];
            CSR_HEIGHT:   image_height = data[12:0];
            CSR_MIN_ITER: min_iterations = data[9:0];
            CSR_MAX_ITER: max_iterations = data[9:0];
            default: ;
         endcase
      endfunction

      // signed product, floored back to the fraction width, wraps to 64 bits
      function logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
         logic signed [127:0] p;
         p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
         return p[FRAC+63:FRAC];
      endfunction

      // floor(4*p/d) - 2; a zero dimension counts as one
      function logic [63:0] start_coord(logic [11:0] p, logic [12:0] d);
         logic [63:0] div;
         div = (d == 0) ? 64'd1 : 64'(d);
         return ((64'(p) << (FRAC + 2)) / div) - (64'd2 << FRAC);
      endfunction

      function void note_pixel(logic [11:0] px, logic [11:0] py);
         logic [63:0] zr, zi, rr, ii, nr, cr, ci;
         logic signed [63:0] mag;
         int count;
         int lv;
         pixel_color_type color;
         zr = start_coord(px, image_width);
         zi = start_coord(py, image_height);
         cr = {{32{c_real[31]}}, c_real};
         ci = {{32{c_imag[31]}}, c_imag};
         count = int'(min_iterations);
         while (1) begin
            rr = q_mul(zr, zr);
            ii = q_mul(zi, zi);
            mag = rr + ii;
            if (mag >= FOUR_Q || count > int'(max_iterations)) break;
            nr = rr - ii + cr;
            zi = (q_mul(zr, zi) << 1) + ci;
            zr = nr;
            count++;
         end
         lv = 0;
         if (count < int'(max_iterations) && max_iterations != 0)
            lv = (255 * count) / int'(max_iterations);
         color.level      = 8'(lv);
         color.red        = (lv != 0) ? LEVEL_FULL : 8'd0;
         color.green_blue = (lv != 0) ? LEVEL_FULL - 8'(lv) : 8'd0;
         colors_due.push_back(color);
      endfunction

      task check_result(logic [7:0] level, logic [7:0] red, logic [7:0] gb);
         pixel_color_type want;
         results_seen++;
         if (colors_due.size() == 0) begin
            report($sformatf("result %0d arrived with no pixel pending", results_seen));
            return;
         end
         want = colors_due.pop_front();
         if (level !== want.level)
            report($sformatf("result %0d escape_level got %0d want %0d",
                             results_seen, level, want.level));
         if (red !== want.red)
            report($sformatf("result %0d red_channel got %0d want %0d",
                             results_seen, red, want.red));
         if (gb !== want.green_blue)
            report($sformatf("result %0d green_blue_channel got %0d want %0d",
                             results_seen, gb, want.green_blue));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   hold_req = 1'b0;
   bit   quiet_stretch = 1'b0;
   int   stuck_cycles = 0;
   pixel_scoreboard sb = new();

   jetp_req_if req_bus ();
   jetp_rsp_if rsp_bus ();
   jetp_csr_if csr_bus ();

   julia_escape_time_pixel_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            sb.write_reg(csr_index_type'(csr_bus.index), csr_bus.data);
         if (req_bus.valid && req_bus.ready)
            sb.note_pixel(req_bus.pixel_x, req_bus.pixel_y);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.escape_level, rsp_bus.red_channel,
                            rsp_bus.green_blue_channel);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("%0t no handshake for %0d cycles", $time, stuck_cycles);
         $display("[julia_escape_time_pixel_core] ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // mostly short gaps, a few long ones, none during a quiet stretch
   function automatic int idle_gap();
      int r;
      if (quiet_stretch) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] pick_c();
      if ($urandom_range(0, 4) == 0) return $urandom();
      // roughly +-1.5 in Q4.28
      return 32'($urandom_range(0, 805306368)) - 32'd402653184;
   endfunction

   function automatic logic [12:0] pick_dim();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return 13'($urandom_range(8, 640));
      if (r < 15) return 13'($urandom_range(1, 4096));
      if (r == 15) return 13'd0;
      if (r == 16) return 13'd8191;
      if (r == 17) return 13'd4096;
      return 13'($urandom_range(0, 8191));
   endfunction

   function automatic logic [9:0] pick_max();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return 10'($urandom_range(1, 48));
      if (r < 95) return 10'($urandom_range(49, 300));
      return 10'd0;
   endfunction

   function automatic logic [9:0] pick_min(logic [9:0] mx);
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 10'd0;
      if (r < 85) return 10'($urandom_range(0, int'(mx)));
      return 10'($urandom_range(0, 1023));
   endfunction

   // coordinate inside the image most of the time, anywhere in the field otherwise
   function automatic logic [11:0] pick_coord(logic [12:0] dim);
      int lim;
      if (dim == 0 || $urandom_range(0, 6) == 0) return 12'($urandom_range(0, 4095));
      lim = (dim > 4096) ? 4095 : int'(dim) - 1;
      return 12'($urandom_range(0, lim));
   endfunction

   task automatic set_cfg(input logic [31:0] cr, input logic [31:0] ci,
                          input logic [12:0] w, input logic [12:0] h,
                          input logic [9:0] mn, input logic [9:0] mx);
      csr_index_type order [6];
      logic [31:0] vals [6];
      order = '{CSR_C_REAL, CSR_C_IMAG, CSR_WIDTH, CSR_HEIGHT, CSR_MIN_ITER, CSR_MAX_ITER};
      vals  = '{cr, ci, 32'(w), 32'(h), 32'(mn), 32'(mx)};
      for (int i = 0; i < 6; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= order[i];
         csr_bus.data  <= vals[i];
         do @(posedge clock); while (!csr_bus.ready);
      end
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
      int gap;
      req_bus.valid   <= 1'b1;
      req_bus.pixel_x <= px;
      req_bus.pixel_y <= py;
      do @(posedge clock); while (!req_bus.ready);
      gap = idle_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending, then wait for every color word to come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(input int n_items, input bit pressure);
      logic [31:0] cr, ci;
      logic [12:0] w, h;
      logic [9:0]  mn, mx;
      cr = pick_c();
      ci = pick_c();
      w  = pick_dim();
      h  = pick_dim();
      // short limit under pressure so the core backs up well within the hold-off
      mx = pressure ? 10'($urandom_range(1, 48)) : pick_max();
      mn = pick_min(mx);
      quiet_stretch = ($urandom_range(0, 3) == 0);
      set_cfg(cr, ci, w, h, mn, mx);
      if (pressure) hold_req <= 1'b1;
      for (int k = 0; k < n_items; k++)
         send_pixel(pick_coord(w), pick_coord(h));
      drain();
   endtask

   initial begin : rsp_sink
      int stall;
      stall = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            // long hold-off so the core backs up into the request side
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req <= 1'b0;
            rsp_bus.ready <= 1'b1;
            stall = 0;
         end else if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall = idle_gap();
         end
      end
   end

   initial begin : stimulus
      req_bus.valid   <= 1'b0;
      req_bus.pixel_x <= '0;
      req_bus.pixel_y <= '0;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= CSR_C_REAL;
      csr_bus.data    <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register values straight out of reset; c = 0 gives the unit circle
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd256, 12'd256);
      send_pixel(12'd384, 12'd256);
      send_pixel(12'd128, 12'd256);
      send_pixel(12'd300, 12'd200);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      drain();

      // extreme c, zero width, widest height, large limit
      set_cfg(32'h8000_0000, 32'h7FFF_FFFF, 13'd0, 13'd8191, 10'd5, 10'd1023);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd1, 12'd2000);
      drain();

      // start count above the limit
      set_cfg(32'd0, 32'd0, 13'd512, 13'd512, 10'd1023, 10'd1);
      send_pixel(12'd256, 12'd256);
      send_pixel(12'd0, 12'd0);
      drain();

      // zero limit
      set_cfg(32'd0, 32'd0, 13'd512, 13'd512, 10'd0, 10'd0);
      send_pixel(12'd256, 12'd256);
      send_pixel(12'd10, 12'd10);
      drain();

      // c = -0.8 + 0.156i at full image size and full iteration range
      set_cfg(32'(-214748365), 32'd41875931, 13'd4096, 13'd4096, 10'd0, 10'd1023);
      send_pixel(12'd2048, 12'd2048);
      send_pixel(12'd1000, 12'd3000);
      send_pixel(12'd4095, 12'd4095);
      drain();

      // one-pixel image, start count equal to the limit
      set_cfg(32'd0, 32'd0, 13'd1, 13'd1, 10'd7, 10'd7);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd1, 12'd1);
      send_pixel(12'd4095, 12'd4095);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++)
         random_phase(ITEMS_PER_PHASE, p == 2);

      if (sb.errors == 0) begin
         $display("[julia_escape_time_pixel_core] OK");
      end else begin
         $display("[julia_escape_time_pixel_core] ERROR");
      end
      $finish;
   end
endmodule
